/* src/mbrh_pkg.sv */
package mbrh_pkg;

  localparam int unsigned MaxRegsDefault = 125;
  localparam logic [31:0] TimeoutReset   = 32'd1000;
  localparam logic [15:0] CrcInit        = 16'hFFFF;
  localparam logic [15:0] CrcPoly        = 16'hA001;
  localparam logic [7:0]  FuncRead       = 8'h03;
  localparam logic [7:0]  FuncExcFlag    = 8'h80;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_DATA   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_PARAM    = 4'd1,
    ST_UNIT     = 4'd2,
    ST_FUNCTION = 4'd3,
    ST_LENGTH   = 4'd4,
    ST_CRC      = 4'd5,
    ST_EXCEPT   = 4'd6,
    ST_TIMEOUT  = 4'd7,
    ST_NO_DATA  = 4'd8
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HDR  = 4'b0010,
    PH_EXC  = 4'b0100,
    PH_BODY = 4'b1000
  } phase_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  unit_id;
    logic [15:0] reg_addr;
    logic [7:0]  qty;
    logic [7:0]  rx_byte;
    logic [6:0]  reg_index;
  } mbrh_in_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic        last;
    status_e     status;
    logic [7:0]  exception_code;
    logic [15:0] reg_value;
  } mbrh_out_t;

  // crc-16/modbus update by one byte, reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

/* src/modbus_rtu_read_holding_master.sv */
// channel | direction | payload    | handshake
// in      | input     | mbrh_in_t  | in_valid_i / in_stall_o, beat when valid and not stall
// out     | output    | mbrh_out_t | out_valid_o / out_stall_i, beat when valid and not stall
// cfg     | input     | 32-bit     | cfg_we_i / cfg_wdata_i, written on any edge with we high
//
// byte, tick and read items are handled and leave the item stage one item per cycle while
// the result register can take a beat; a start item with a good quantity holds the item
// stage through its eight result beats, which leave one a cycle through the single result
// register when not stalled; the request checksum is built a byte a beat as the bytes go out
// a read item sees the buffer through a registered memory read done as the item is taken in
// reset clears all control state; the register buffer is not cleared and needs no clearing pass
// output stall holds the result register; the item stage still takes one item behind it
module modbus_rtu_read_holding_master
  import mbrh_pkg::*;
#(
  parameter int unsigned MaxRegs = MaxRegsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  mbrh_in_t    in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output mbrh_out_t   out_o
);

  localparam int unsigned IdxW = (MaxRegs > 1) ? $clog2(MaxRegs) : 1;

  // item stage
  logic       in_valid_q;
  mbrh_in_t   in_q;
  logic       accept;
  logic       item_go;
  logic       consume;

  // result register
  logic       out_valid_q;
  mbrh_out_t  out_q;
  mbrh_out_t  out_d;
  logic       out_load;
  logic       out_ok;

  // request burst
  logic [2:0]  tx_cnt_q, tx_cnt_d;
  logic [15:0] tx_crc_q, tx_crc_d;
  logic [15:0] tx_crc_in;
  logic [7:0]  tx_sel;

  // receiver state
  phase_e      phase_q, phase_d;
  logic [15:0] crc_acc_q, crc_acc_d;
  logic [7:0]  exp_unit_q, exp_unit_d;
  logic [7:0]  exp_count_q, exp_count_d;
  logic [7:0]  byte_pos_q, byte_pos_d;
  logic [7:0]  hi_hold_q, hi_hold_d;
  logic [7:0]  exc_hold_q, exc_hold_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [31:0] idle_ticks_q, idle_ticks_d;
  logic        data_valid_q, data_valid_d;
  logic [31:0] timeout_q;

  // register buffer
  logic [15:0]     mem [MaxRegs];
  logic [15:0]     rd_data_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [15:0]     mem_wdata;

  // scratch
  logic        qty_ok;
  logic [15:0] crc_rx;
  logic [15:0] frame_crc;
  logic [31:0] ticks_inc;

  assign out_ok     = !out_valid_q || !out_stall_i;
  assign item_go    = in_valid_q && out_ok;
  assign in_stall_o = in_valid_q && !consume;
  assign accept     = in_valid_i && !in_stall_o;

  assign qty_ok    = (in_q.qty != 8'd0) && (in_q.qty <= 8'(MaxRegs));
  assign crc_rx    = crc_byte(crc_acc_q, in_q.rx_byte);
  assign frame_crc = {in_q.rx_byte, crc_lo_q};
  assign ticks_inc = (idle_ticks_q == 32'hFFFF_FFFF) ? idle_ticks_q : idle_ticks_q + 32'd1;

  // request byte for the current beat of the burst
  assign tx_crc_in = (tx_cnt_q == 3'd0) ? CrcInit : tx_crc_q;
  always_comb begin
    unique case (tx_cnt_q)
      3'd0:    tx_sel = in_q.unit_id;
      3'd1:    tx_sel = FuncRead;
      3'd2:    tx_sel = in_q.reg_addr[15:8];
      3'd3:    tx_sel = in_q.reg_addr[7:0];
      3'd4:    tx_sel = 8'h00;
      3'd5:    tx_sel = in_q.qty;
      3'd6:    tx_sel = tx_crc_q[7:0];
      default: tx_sel = tx_crc_q[15:8];
    endcase
  end

  always_comb begin
    consume      = item_go;
    out_load     = 1'b0;
    out_d        = '{kind: KIND_STATUS, status: ST_OK, default: '0};
    tx_cnt_d     = tx_cnt_q;
    tx_crc_d     = tx_crc_q;
    phase_d      = phase_q;
    crc_acc_d    = crc_acc_q;
    exp_unit_d   = exp_unit_q;
    exp_count_d  = exp_count_q;
    byte_pos_d   = byte_pos_q;
    hi_hold_d    = hi_hold_q;
    exc_hold_d   = exc_hold_q;
    crc_lo_d     = crc_lo_q;
    idle_ticks_d = idle_ticks_q;
    data_valid_d = data_valid_q;
    mem_we       = 1'b0;
    mem_waddr    = byte_pos_q[IdxW:1];
    mem_wdata    = {hi_hold_q, in_q.rx_byte};

    if (item_go) begin
      unique case (in_q.op)
        OP_START: begin
          if (!qty_ok) begin
            out_load   = 1'b1;
            out_d.status = ST_PARAM;
            phase_d    = PH_IDLE;
          end else begin
            // one request byte a beat, item leaves on the eighth
            out_load      = 1'b1;
            out_d.kind    = KIND_TX;
            out_d.tx_byte = tx_sel;
            out_d.last    = (tx_cnt_q == 3'd7);
            tx_cnt_d      = tx_cnt_q + 3'd1;
            if (tx_cnt_q < 3'd6) begin
              tx_crc_d = crc_byte(tx_crc_in, tx_sel);
            end
            consume = (tx_cnt_q == 3'd7);
            if (tx_cnt_q == 3'd7) begin
              phase_d      = PH_HDR;
              crc_acc_d    = CrcInit;
              exp_unit_d   = in_q.unit_id;
              exp_count_d  = {in_q.qty[6:0], 1'b0};
              byte_pos_d   = 8'd0;
              idle_ticks_d = 32'd0;
              data_valid_d = 1'b0;
            end
          end
        end
        OP_BYTE: begin
          if (phase_q != PH_IDLE) begin
            idle_ticks_d = 32'd0;
          end
          unique case (phase_q)
            PH_IDLE: begin
            end
            PH_HDR: begin
              crc_acc_d = crc_rx;
              if (byte_pos_q == 8'd0) begin
                hi_hold_d  = in_q.rx_byte;
                byte_pos_d = 8'd1;
              end else if (byte_pos_q == 8'd1) begin
                exc_hold_d = in_q.rx_byte;
                byte_pos_d = 8'd2;
              end else begin
                byte_pos_d = 8'd0;
                // header checks in line order
                if (hi_hold_q != exp_unit_q) begin
                  out_load     = 1'b1;
                  out_d.status = ST_UNIT;
                  phase_d      = PH_IDLE;
                end else if (exc_hold_q == (FuncRead | FuncExcFlag)) begin
                  exc_hold_d = in_q.rx_byte;
                  phase_d    = PH_EXC;
                end else if (exc_hold_q != FuncRead) begin
                  out_load     = 1'b1;
                  out_d.status = ST_FUNCTION;
                  phase_d      = PH_IDLE;
                end else if (in_q.rx_byte != exp_count_q) begin
                  out_load     = 1'b1;
                  out_d.status = ST_LENGTH;
                  phase_d      = PH_IDLE;
                end else begin
                  phase_d = PH_BODY;
                end
              end
            end
            PH_EXC: begin
              if (byte_pos_q == 8'd0) begin
                crc_lo_d   = in_q.rx_byte;
                byte_pos_d = 8'd1;
              end else begin
                byte_pos_d = 8'd0;
                out_load   = 1'b1;
                phase_d    = PH_IDLE;
                if (frame_crc != crc_acc_q) begin
                  out_d.status = ST_CRC;
                end else begin
                  out_d.status         = ST_EXCEPT;
                  out_d.exception_code = exc_hold_q;
                end
              end
            end
            PH_BODY: begin
              if (byte_pos_q < exp_count_q) begin
                crc_acc_d  = crc_rx;
                byte_pos_d = byte_pos_q + 8'd1;
                if (!byte_pos_q[0]) begin
                  hi_hold_d = in_q.rx_byte;
                end else begin
                  mem_we = ({1'b0, byte_pos_q[7:1]} < 8'(MaxRegs));
                end
              end else if (byte_pos_q == exp_count_q) begin
                crc_lo_d   = in_q.rx_byte;
                byte_pos_d = byte_pos_q + 8'd1;
              end else begin
                byte_pos_d = 8'd0;
                out_load   = 1'b1;
                phase_d    = PH_IDLE;
                if (frame_crc != crc_acc_q) begin
                  out_d.status = ST_CRC;
                end else begin
                  out_d.status = ST_OK;
                  data_valid_d = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
        OP_TICK: begin
          if (phase_q != PH_IDLE) begin
            idle_ticks_d = ticks_inc;
            if (ticks_inc >= timeout_q) begin
              out_load     = 1'b1;
              out_d.status = ST_TIMEOUT;
              phase_d      = PH_IDLE;
            end
          end
        end
        OP_READ: begin
          out_load = 1'b1;
          if (!data_valid_q || (in_q.reg_index >= exp_count_q[7:1])
              || ({1'b0, in_q.reg_index} >= 8'(MaxRegs))) begin
            out_d.status = ST_NO_DATA;
          end else begin
            out_d.kind      = KIND_DATA;
            out_d.reg_value = rd_data_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // item stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
  end

  // register buffer, read as the item is taken in
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept && ({1'b0, in_i.reg_index} < 8'(MaxRegs))) begin
      rd_data_q <= mem[in_i.reg_index[IdxW-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // control and receiver state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_cnt_q     <= 3'd0;
      tx_crc_q     <= CrcInit;
      phase_q      <= PH_IDLE;
      crc_acc_q    <= CrcInit;
      exp_unit_q   <= 8'd0;
      exp_count_q  <= 8'd0;
      byte_pos_q   <= 8'd0;
      hi_hold_q    <= 8'd0;
      exc_hold_q   <= 8'd0;
      crc_lo_q     <= 8'd0;
      idle_ticks_q <= 32'd0;
      data_valid_q <= 1'b0;
      timeout_q    <= TimeoutReset;
    end else begin
      tx_cnt_q     <= tx_cnt_d;
      tx_crc_q     <= tx_crc_d;
      phase_q      <= phase_d;
      crc_acc_q    <= crc_acc_d;
      exp_unit_q   <= exp_unit_d;
      exp_count_q  <= exp_count_d;
      byte_pos_q   <= byte_pos_d;
      hi_hold_q    <= hi_hold_d;
      exc_hold_q   <= exc_hold_d;
      crc_lo_q     <= crc_lo_d;
      idle_ticks_q <= idle_ticks_d;
      data_valid_q <= data_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* sim/modbus_rtu_read_holding_master_test.sv */
`timescale 1ns / 100ps

module modbus_rtu_read_holding_master_test;
  import mbrh_pkg::*;

  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned HoldOffCycles  = 300;
  // longest item (a start) holds the item stage through its eight result beats, plus the result register
  localparam int unsigned SettleCycles   = 12;
  localparam int unsigned RandomPerPhase = 14;

  // how a reply frame is closed off
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_GOOD,
    TAIL_BAD
  } tail_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  mbrh_in_t    in_i        = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  mbrh_out_t   out_o;

  // run control
  int unsigned errors       = 0;
  int unsigned items_done   = 0;
  int unsigned cycle_count  = 0;
  int unsigned gap_pct      = 20;
  bit          calm         = 1'b0;
  bit          hold_off_req = 1'b0;

  // master state as seen from the line, kept in step with accepted beats
  logic [31:0] timeout_cfg;
  phase_e      link_phase;
  logic [15:0] rx_crc;
  logic [7:0]  want_unit;
  logic [7:0]  want_count;
  logic [7:0]  rx_pos;
  logic [7:0]  hi_hold;
  logic [7:0]  exc_hold;
  logic [7:0]  crc_lo_hold;
  logic [31:0] idle_count;
  logic [15:0] reg_copy [MaxRegsDefault];
  logic        copy_valid;

  // result beats still owed by the block, oldest first
  mbrh_out_t   response_q[$];

  modbus_rtu_read_holding_master dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- prediction

  // crc-16/modbus, folding in one data bit per shift
  function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ data[i];
      r  = {1'b0, r[15:1]} ^ (fb ? CrcPoly : 16'h0000);
    end
    return r;
  endfunction

  function automatic mbrh_out_t status_beat(input status_e st, input logic [7:0] code);
    mbrh_out_t r;
    r                = '0;
    r.kind           = KIND_STATUS;
    r.status         = st;
    r.exception_code = code;
    return r;
  endfunction

  // a status that ends the transaction
  function automatic void finish_with(input status_e st, input logic [7:0] code);
    response_q.push_back(status_beat(st, code));
    link_phase = PH_IDLE;
  endfunction

  function automatic void reset_master_state();
    timeout_cfg = TimeoutReset;
    link_phase  = PH_IDLE;
    rx_crc      = CrcInit;
    want_unit   = '0;
    want_count  = '0;
    rx_pos      = '0;
    hi_hold     = '0;
    exc_hold    = '0;
    crc_lo_hold = '0;
    idle_count  = '0;
    copy_valid  = 1'b0;
    foreach (reg_copy[i]) reg_copy[i] = '0;
  endfunction

  // advance the master by one accepted item and queue the beats it owes
  function automatic void compute_responses(input mbrh_in_t item);
    mbrh_out_t   r;
    logic [7:0]  req [8];
    logic [15:0] c;
    logic [7:0]  b;
    b = item.rx_byte;
    case (item.op)
      OP_START: begin
        if (item.qty == 8'd0 || item.qty > MaxRegsDefault) begin
          // buffer, data flag and last quantity survive a rejected start
          finish_with(ST_PARAM, 8'h00);
        end else begin
          req[0] = item.unit_id;
          req[1] = FuncRead;
          req[2] = item.reg_addr[15:8];
          req[3] = item.reg_addr[7:0];
          req[4] = 8'h00;
          req[5] = item.qty;
          c = CrcInit;
          for (int i = 0; i < 6; i++) c = crc16_update(c, req[i]);
          req[6] = c[7:0];
          req[7] = c[15:8];
          for (int i = 0; i < 8; i++) begin
            r         = '0;
            r.kind    = KIND_TX;
            r.tx_byte = req[i];
            r.last    = (i == 7);
            response_q.push_back(r);
          end
          // a new start drops whatever was in flight
          link_phase = PH_HDR;
          rx_crc     = CrcInit;
          want_unit  = item.unit_id;
          want_count = {item.qty[6:0], 1'b0};
          rx_pos     = '0;
          idle_count = '0;
          copy_valid = 1'b0;
        end
      end
      OP_BYTE: begin
        if (link_phase != PH_IDLE) begin
          idle_count = '0;
          case (link_phase)
            PH_HDR: begin
              rx_crc = crc16_update(rx_crc, b);
              if (rx_pos == 8'd0) begin
                hi_hold = b;
                rx_pos  = 8'd1;
              end else if (rx_pos == 8'd1) begin
                exc_hold = b;
                rx_pos   = 8'd2;
              end else begin
                // full header in hand: unit, then function, then byte count
                rx_pos = '0;
                if (hi_hold != want_unit) begin
                  finish_with(ST_UNIT, 8'h00);
                end else if (exc_hold == (FuncRead | FuncExcFlag)) begin
                  exc_hold   = b;
                  link_phase = PH_EXC;
                end else if (exc_hold != FuncRead) begin
                  finish_with(ST_FUNCTION, 8'h00);
                end else if (b != want_count) begin
                  finish_with(ST_LENGTH, 8'h00);
                end else begin
                  link_phase = PH_BODY;
                end
              end
            end
            PH_EXC: begin
              if (rx_pos == 8'd0) begin
                crc_lo_hold = b;
                rx_pos      = 8'd1;
              end else begin
                rx_pos = '0;
                if ({b, crc_lo_hold} != rx_crc) finish_with(ST_CRC, 8'h00);
                else finish_with(ST_EXCEPT, exc_hold);
              end
            end
            default: begin
              // register data, big-endian pairs, then the crc low and high
              if (rx_pos < want_count) begin
                rx_crc = crc16_update(rx_crc, b);
                if (!rx_pos[0]) hi_hold = b;
                else reg_copy[rx_pos[7:1]] = {hi_hold, b};
                rx_pos++;
              end else if (rx_pos == want_count) begin
                crc_lo_hold = b;
                rx_pos++;
              end else begin
                rx_pos = '0;
                if ({b, crc_lo_hold} != rx_crc) begin
                  finish_with(ST_CRC, 8'h00);
                end else begin
                  copy_valid = 1'b1;
                  finish_with(ST_OK, 8'h00);
                end
              end
            end
          endcase
        end
      end
      OP_TICK: begin
        if (link_phase != PH_IDLE) begin
          if (idle_count != '1) idle_count++;
          // a limit of zero trips on the first tick, same as one
          if (idle_count >= timeout_cfg) finish_with(ST_TIMEOUT, 8'h00);
        end
      end
      default: begin
        if (!copy_valid || item.reg_index >= want_count[7:1]) begin
          response_q.push_back(status_beat(ST_NO_DATA, 8'h00));
        end else begin
          r           = '0;
          r.kind      = KIND_DATA;
          r.reg_value = reg_copy[item.reg_index];
          response_q.push_back(r);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // each result beat against the oldest one owed
  always @(posedge clk_i) begin
    mbrh_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (response_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got %h", $time, out_o);
      end else begin
        want = response_q.pop_front();
        compare_field("kind", 16'(want.kind), 16'(out_o.kind));
        compare_field("tx_byte", 16'(want.tx_byte), 16'(out_o.tx_byte));
        compare_field("last", 16'(want.last), 16'(out_o.last));
        compare_field("status", 16'(want.status), 16'(out_o.status));
        compare_field("exception_code", 16'(want.exception_code),
                      16'(out_o.exception_code));
        compare_field("reg_value", want.reg_value, out_o.reg_value);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver pacing

  // random stall bursts and free runs; one long hold-off on request, counted here
  initial begin
    int unsigned n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        n = $urandom_range(1, 20);
        out_stall_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------- sending

  // unused fields carry random bits so the block is seen to ignore them
  function automatic mbrh_in_t any_item(input op_e op);
    mbrh_in_t    it;
    logic [63:0] raw;
    raw   = {$urandom, $urandom};
    it    = raw[$bits(mbrh_in_t)-1:0];
    it.op = op;
    return it;
  endfunction

  // one input beat: offer, hold until taken, then maybe a random gap
  task automatic send_item(input mbrh_in_t item);
    in_i       <= item;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // bytes and ticks with no transaction open are ignored and not counted
    if (!((item.op == OP_BYTE || item.op == OP_TICK) && link_phase == PH_IDLE)) items_done++;
    compute_responses(item);
    if (!calm && $urandom_range(1, 100) <= gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic send_start(input logic [7:0] unit, input logic [15:0] addr,
                            input logic [7:0] qty);
    mbrh_in_t it;
    it          = any_item(OP_START);
    it.unit_id  = unit;
    it.reg_addr = addr;
    it.qty      = qty;
    send_item(it);
  endtask

  task automatic send_byte(input logic [7:0] b);
    mbrh_in_t it;
    it         = any_item(OP_BYTE);
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic send_tick();
    send_item(any_item(OP_TICK));
  endtask

  task automatic send_read(input logic [6:0] idx);
    mbrh_in_t it;
    it           = any_item(OP_READ);
    it.reg_index = idx;
    send_item(it);
  endtask

  // a tick now and then between bytes, never enough to time out
  task automatic stray_tick(input bit mix_ticks);
    if (mix_ticks && 64'(idle_count) + 1 < 64'(timeout_cfg) && $urandom_range(0, 3) == 0) begin
      send_tick();
    end
  endtask

  // slave reply: the given bytes, then optionally the crc, possibly spoilt
  task automatic send_frame(input logic [7:0] body[$], input tail_e tail, input bit mix_ticks);
    logic [15:0] c;
    c = CrcInit;
    foreach (body[i]) begin
      c = crc16_update(c, body[i]);
      stray_tick(mix_ticks);
      send_byte(body[i]);
    end
    if (tail != TAIL_NONE) begin
      if (tail == TAIL_BAD) c = c ^ (16'h0001 << $urandom_range(0, 15));
      stray_tick(mix_ticks);
      send_byte(c[7:0]);
      stray_tick(mix_ticks);
      send_byte(c[15:8]);
    end
  endtask

  // well-formed register reply with random data
  task automatic send_reply(input logic [7:0] unit, input int unsigned qty, input tail_e tail);
    logic [7:0] body[$];
    body = '{unit, FuncRead, 8'(2 * qty)};
    repeat (2 * qty) body.push_back(8'($urandom));
    send_frame(body, tail, 1'b1);
  endtask

  task automatic wait_for_drain();
    while (response_q.size() != 0) @(posedge clk_i);
  endtask

  // timeout limit only changes with the block quiet
  task automatic set_timeout(input logic [31:0] value);
    in_valid_i <= 1'b0;
    wait_for_drain();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    timeout_cfg = value;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= $urandom;
  endtask

  // ---------------------------------------------------------------- tests

  // bytes and ticks with nothing open, and a read before any data
  task automatic test_idle_items();
    send_tick();
    send_byte(8'hFF);
    send_read(7'h7F);
  endtask

  task automatic test_bad_quantity();
    send_start(8'h00, 16'h0000, 8'd0);
    send_start(8'hFF, 16'hFFFF, 8'd126);
    send_start(8'hA5, 16'h5A5A, 8'd255);
  endtask

  // largest request cut short by a fresh start, then a good one-register reply
  task automatic test_good_frame();
    send_start(8'hFF, 16'hFFFF, 8'd125);
    send_start(8'h00, 16'h0000, 8'd1);
    send_reply(8'h00, 1, TAIL_GOOD);
    send_read(7'd0);
    send_read(7'd1);
  endtask

  task automatic test_exception_reply();
    logic [7:0] body[$];
    body = '{8'h11, FuncRead | FuncExcFlag, 8'h02};
    send_start(8'h11, 16'h1234, 8'd7);
    send_frame(body, TAIL_GOOD, 1'b0);
  endtask

  // shortest limits: one tick and zero, which behaves as one
  task automatic test_timeout();
    set_timeout(32'd1);
    send_start(8'h42, 16'h0100, 8'd3);
    send_tick();
    set_timeout(32'd0);
    send_start(8'h43, 16'h0200, 8'd4);
    send_tick();
  endtask

  // whole buffer filled once, read at both ends and just past
  task automatic test_full_buffer();
    logic [7:0] unit;
    logic [7:0] body[$];
    unit = 8'($urandom);
    set_timeout(32'd1000);
    send_start(unit, 16'($urandom), 8'(MaxRegsDefault));
    body = '{unit, FuncRead, 8'(2 * MaxRegsDefault)};
    repeat (2 * MaxRegsDefault) body.push_back(8'($urandom));
    send_frame(body, TAIL_GOOD, 1'b0);
    send_read(7'(MaxRegsDefault - 1));
    send_read(7'd0);
    send_read(7'(MaxRegsDefault));
  endtask

  // receiver holds off while requests keep coming, so the input backs up
  task automatic test_backpressure();
    gap_pct      = 0;
    hold_off_req = 1'b1;
    repeat (6) begin
      send_start(8'($urandom), 16'($urandom), 8'($urandom_range(1, MaxRegsDefault)));
    end
    send_read(7'($urandom));
    gap_pct = 20;
  endtask

  // mostly well-formed exchanges with random content, some broken, some noise
  task automatic test_random_traffic(input logic [31:0] limit, input int unsigned gaps);
    int unsigned goal;
    int unsigned pick;
    int unsigned q;
    int unsigned keep;
    logic [7:0]  unit;
    logic [7:0]  f;
    logic [7:0]  body[$];
    set_timeout(limit);
    gap_pct = gaps;
    goal    = items_done + RandomPerPhase;
    while (items_done < goal) begin
      pick = $urandom_range(0, 99);
      unit = 8'($urandom);
      q    = ($urandom_range(0, 14) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
      if (pick < 8) begin
        // rejected quantity, then a read that sees whatever was kept
        send_start(unit, 16'($urandom), ($urandom_range(0, 1) != 0) ? 8'd0 :
                   8'($urandom_range(MaxRegsDefault + 1, 255)));
        send_read(7'($urandom_range(0, 127)));
      end else if (pick < 16) begin
        // line noise
        repeat ($urandom_range(1, 4)) send_item(any_item(op_e'($urandom_range(0, 3))));
      end else begin
        send_start(unit, 16'($urandom), 8'(q));
        body = '{unit, FuncRead, 8'(2 * q)};
        if (pick < 22) begin
          // reply from the wrong slave
          body[0] = unit ^ 8'($urandom_range(1, 255));
          send_frame(body, TAIL_NONE, 1'b1);
        end else if (pick < 28) begin
          do f = 8'($urandom); while (f == FuncRead || f == (FuncRead | FuncExcFlag));
          body[1] = f;
          send_frame(body, TAIL_NONE, 1'b1);
        end else if (pick < 34) begin
          body[2] = 8'(2 * q) ^ 8'($urandom_range(1, 255));
          send_frame(body, TAIL_NONE, 1'b1);
        end else if (pick < 44) begin
          // exception reply, crc good or spoilt
          body[1] = FuncRead | FuncExcFlag;
          body[2] = 8'($urandom);
          send_frame(body, ($urandom_range(0, 1) != 0) ? TAIL_GOOD : TAIL_BAD, 1'b1);
        end else if (pick < 52) begin
          send_reply(unit, q, TAIL_BAD);
        end else if (pick < 66) begin
          // reply cut short; up to twelve ticks toward the timeout, or a fresh start takes over
          repeat (2 * q) body.push_back(8'($urandom));
          keep = $urandom_range(0, body.size() - 1);
          while (body.size() > keep) void'(body.pop_back());
          send_frame(body, TAIL_NONE, 1'b1);
          if (pick < 60) begin
            for (int n = 0; n < 12 && link_phase != PH_IDLE; n++) send_tick();
          end
        end else begin
          send_reply(unit, q, TAIL_GOOD);
          repeat ($urandom_range(0, 3)) begin
            send_read(7'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) :
                         $urandom_range(0, q)));
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    reset_master_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_items();
    test_bad_quantity();
    test_good_frame();
    test_exception_reply();
    test_timeout();
    test_full_buffer();
    test_backpressure();

    // limit settings from the largest down to zero, with varying sender gaps
    test_random_traffic(32'hFFFF_FFFF, 30);
    test_random_traffic(32'd3, 0);
    test_random_traffic(32'd1, 15);
    test_random_traffic(32'd0, 40);
    // last stretch at full rate on both sides
    calm = 1'b1;
    test_random_traffic(32'd9, 0);

    in_valid_i <= 1'b0;
    wait_for_drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
src/mbrh_pkg.sv
src/modbus_rtu_read_holding_master.sv
sim/modbus_rtu_read_holding_master_test.sv
